/* hw/rtl/lr_pkg.sv */
// Shared types and constants for the line rasterizer.
// No dependencies; compile first.
`default_nettype none

package lr_pkg;

  localparam int DIM_BITS      = 11;
  localparam int COLOR_BITS    = 32;
  localparam int CFG_ADDR_BITS = 2;

  typedef logic [DIM_BITS-1:0]      dim_t;
  typedef logic [COLOR_BITS-1:0]    color_t;
  typedef logic [CFG_ADDR_BITS-1:0] cfg_addr_t;

  // Request kinds carried on the action field.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  // Configuration register indexes.
  localparam cfg_addr_t REG_SCREEN_WIDTH  = 2'd0;
  localparam cfg_addr_t REG_SCREEN_HEIGHT = 2'd1;

  localparam dim_t SCREEN_WIDTH_RST  = 11'd640;
  localparam dim_t SCREEN_HEIGHT_RST = 11'd480;

endpackage

`default_nettype wire

/* hw/rtl/lr_channels.sv */
// Valid/ready channel interfaces for the line rasterizer: request in, pixel out.
// Depends on lr_pkg.
`default_nettype none

interface lr_in_if #(
  parameter int COORD_BITS = 12
);
  import lr_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         action;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  color_t                       pixel_color;

  modport source (
    output valid, action, start_x, start_y, end_x, end_y, pixel_color,
    input  ready
  );
  modport sink (
    input  valid, action, start_x, start_y, end_x, end_y, pixel_color,
    output ready
  );
endinterface

interface lr_out_if #(
  parameter int COORD_BITS = 12
);
  import lr_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  color_t                       color_out;
  logic                         in_window;
  logic                         last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, color_out, in_window, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, color_out, in_window, last_pixel,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/line_rasterizer_top.sv */
// Bresenham line rasterizer: line setup on load requests, one pixel per step request while a line is active.
// Depends on lr_pkg and the lr_in_if / lr_out_if channel interfaces.
// A step request is held in the input register, then its pixel in the result register that drives the out channel.
// Throughput: one request per cycle unless a step stalls; the decision-term add and compare are combinational.
// A load request gives no pixel and is retired in the cycle after its acceptance.
// Reset (rst_n low, synchronous): both channels empty, no line active, window 640 x 480.
`default_nettype none

module line_rasterizer_top #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  lr_in_if.sink                             in_req,
  lr_out_if.source                          out_res,
  input  wire logic                         cfg_we,
  input  wire lr_pkg::cfg_addr_t            cfg_addr,
  input  wire lr_pkg::dim_t                 cfg_wdata
);
  import lr_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int DW    = COORD_BITS + 2;
  // Width for the window compare: the magnitude bits of a coordinate or a dimension.
  localparam int CMP_W = (CW - 1 > DIM_BITS) ? CW - 1 : DIM_BITS;

  localparam logic signed [CW-1:0] ONE = CW'(1);

  typedef logic signed [CW-1:0]   coord_t;
  typedef logic signed [CW:0]     delta_t;
  typedef logic signed [DW-1:0]   dterm_t;

  // ---------------------------------------------------------------------------
  // Window configuration. The user must write only while the block is idle; the block itself does not enforce this.
  // ---------------------------------------------------------------------------
  dim_t screen_width_r, screen_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= SCREEN_WIDTH_RST;
      screen_height_r <= SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SCREEN_WIDTH:  screen_width_r  <= cfg_wdata;
        REG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata;
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register: hold one request until the processing stage takes it.
  // ---------------------------------------------------------------------------
  logic   req_valid_r;
  logic   req_action_r;
  coord_t req_ax_r, req_ay_r, req_bx_r, req_by_r;
  color_t req_color_r;

  logic   req_fire;   // processing stage consumes the held request
  logic   emit;       // the held request produces a pixel

  assign in_req.ready = !req_valid_r || req_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      req_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      req_action_r <= in_req.action;
      req_ax_r     <= in_req.start_x;
      req_ay_r     <= in_req.start_y;
      req_bx_r     <= in_req.end_x;
      req_by_r     <= in_req.end_y;
      req_color_r  <= in_req.pixel_color;
    end
  end

  // ---------------------------------------------------------------------------
  // Line state.
  // ---------------------------------------------------------------------------
  logic   line_active_r,  line_active_nxt;
  logic   axes_swapped_r, axes_swapped_nxt;
  logic   minor_down_r,   minor_down_nxt;
  coord_t major_pos_r,    major_pos_nxt;
  coord_t minor_pos_r,    minor_pos_nxt;
  coord_t major_end_r,    major_end_nxt;
  dterm_t decision_r,     decision_nxt;
  dterm_t keep_inc_r,     keep_inc_nxt;
  dterm_t step_inc_r,     step_inc_nxt;
  color_t line_color_r,   line_color_nxt;

  logic   out_valid_r;

  // A load never waits on the output; a step waits for a free result register.
  assign req_fire = req_valid_r &&
                    (req_action_r == ACT_LOAD || !out_valid_r || out_res.ready);
  assign emit     = req_fire && req_action_r == ACT_STEP && line_active_r;

  // ---------------------------------------------------------------------------
  // Load setup: swap axes for steep lines, order endpoints along the major axis.
  // ---------------------------------------------------------------------------
  delta_t dx_raw, dy_raw, adx, ady, dmaj, dmin;
  logic   steep, reorder;
  coord_t p0, p1, q0, q1;
  coord_t maj_start, maj_stop, min_start, min_stop;

  always_comb begin
    dx_raw = delta_t'(req_bx_r) - delta_t'(req_ax_r);
    dy_raw = delta_t'(req_by_r) - delta_t'(req_ay_r);
    adx    = dx_raw[CW] ? -dx_raw : dx_raw;
    ady    = dy_raw[CW] ? -dy_raw : dy_raw;
    steep  = ady > adx;

    p0 = steep ? req_ay_r : req_ax_r;
    q0 = steep ? req_ax_r : req_ay_r;
    p1 = steep ? req_by_r : req_bx_r;
    q1 = steep ? req_bx_r : req_by_r;

    reorder   = p0 > p1;
    maj_start = reorder ? p1 : p0;
    maj_stop  = reorder ? p0 : p1;
    min_start = reorder ? q1 : q0;
    min_stop  = reorder ? q0 : q1;

    // Major and minor extents are the absolute deltas, picked by steepness.
    dmaj = steep ? ady : adx;
    dmin = steep ? adx : ady;
  end

  // ---------------------------------------------------------------------------
  // Step: current pixel, window test, and decision-term advance.
  // ---------------------------------------------------------------------------
  coord_t scr_x, scr_y;
  logic   in_win, last;

  always_comb begin
    scr_x  = axes_swapped_r ? minor_pos_r : major_pos_r;
    scr_y  = axes_swapped_r ? major_pos_r : minor_pos_r;
    in_win = !scr_x[CW-1] && (CMP_W'(scr_x[CW-2:0]) < CMP_W'(screen_width_r)) &&
             !scr_y[CW-1] && (CMP_W'(scr_y[CW-2:0]) < CMP_W'(screen_height_r));
    last   = major_pos_r >= major_end_r;
  end

  always_comb begin
    line_active_nxt  = line_active_r;
    axes_swapped_nxt = axes_swapped_r;
    minor_down_nxt   = minor_down_r;
    major_pos_nxt    = major_pos_r;
    minor_pos_nxt    = minor_pos_r;
    major_end_nxt    = major_end_r;
    decision_nxt     = decision_r;
    keep_inc_nxt     = keep_inc_r;
    step_inc_nxt     = step_inc_r;
    line_color_nxt   = line_color_r;

    if (req_fire && req_action_r == ACT_LOAD) begin
      // Replace any line in flight.
      line_active_nxt  = 1'b1;
      axes_swapped_nxt = steep;
      minor_down_nxt   = min_start > min_stop;
      major_pos_nxt    = maj_start;
      minor_pos_nxt    = min_start;
      major_end_nxt    = maj_stop;
      keep_inc_nxt     = dterm_t'(dmin) <<< 1;
      step_inc_nxt     = (dterm_t'(dmin) - dterm_t'(dmaj)) <<< 1;
      decision_nxt     = (dterm_t'(dmin) <<< 1) - dterm_t'(dmaj);
      line_color_nxt   = req_color_r;
    end else if (emit) begin
      if (last) begin
        line_active_nxt = 1'b0;
      end else begin
        major_pos_nxt = major_pos_r + ONE;
        if (!decision_r[DW-1]) begin
          decision_nxt  = decision_r + step_inc_r;
          minor_pos_nxt = minor_down_r ? minor_pos_r - ONE : minor_pos_r + ONE;
        end else begin
          decision_nxt  = decision_r + keep_inc_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_active_r <= 1'b0;
    end else begin
      line_active_r <= line_active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    axes_swapped_r <= axes_swapped_nxt;
    minor_down_r   <= minor_down_nxt;
    major_pos_r    <= major_pos_nxt;
    minor_pos_r    <= minor_pos_nxt;
    major_end_r    <= major_end_nxt;
    decision_r     <= decision_nxt;
    keep_inc_r     <= keep_inc_nxt;
    step_inc_r     <= step_inc_nxt;
    line_color_r   <= line_color_nxt;
  end

  // ---------------------------------------------------------------------------
  // Result register: hold the pixel until the sink takes it.
  // ---------------------------------------------------------------------------
  coord_t pix_x_r, pix_y_r;
  color_t pix_color_r;
  logic   pix_inside_r, pix_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pix_x_r      <= scr_x;
      pix_y_r      <= scr_y;
      pix_color_r  <= line_color_r;
      pix_inside_r <= in_win;
      pix_last_r   <= last;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.pixel_x    = pix_x_r;
  assign out_res.pixel_y    = pix_y_r;
  assign out_res.color_out  = pix_color_r;
  assign out_res.in_window  = pix_inside_r;
  assign out_res.last_pixel = pix_last_r;

endmodule

`default_nettype wire
